// File: src/pcsc_pkg.sv
`timescale 1ns / 1ps

package pcsc_pkg;

  localparam int unsigned HDR_LEN  = 13;
  localparam int unsigned SIG_LEN  = 8;
  localparam int unsigned TDATA_W  = 184;
  localparam int unsigned TUSER_W  = 4;

  localparam logic [31:0] CRC_POLY  = 32'hEDB8_8320;
  localparam logic [31:0] CRC_INIT  = 32'hFFFF_FFFF;
  localparam logic [31:0] NAME_IHDR = 32'h4948_4452;
  localparam logic [31:0] NAME_IEND = 32'h4945_4E44;
  localparam logic [31:0] NAME_IDAT = 32'h4944_4154;

  typedef enum logic [2:0] {
    PH_SIG  = 3'd0,
    PH_LEN  = 3'd1,
    PH_NAME = 3'd2,
    PH_DATA = 3'd3,
    PH_CRC  = 3'd4,
    PH_DONE = 3'd5,
    PH_ERR  = 3'd6
  } phase_e;

  typedef enum logic [3:0] {
    EV_BUSY      = 4'd0,
    EV_SIG_OK    = 4'd1,
    EV_HEADER    = 4'd2,
    EV_DATA      = 4'd3,
    EV_CHUNK_OK  = 4'd4,
    EV_SIG_ERR   = 4'd5,
    EV_CRC_ERR   = 4'd6,
    EV_NAME_ERR  = 4'd7,
    EV_FIRST_ERR = 4'd8,
    EV_IEND      = 4'd9,
    EV_IGNORED   = 4'd10
  } event_e;

  typedef struct packed {
    event_e      event_res;
    logic [7:0]  out_byte;
    logic [31:0] chunk_length;
    logic [31:0] chunk_name;
    logic        is_idat;
    logic [31:0] image_width;
    logic [31:0] image_height;
    logic [7:0]  sample_depth;
    logic [7:0]  pixel_kind;
    logic [7:0]  compression_kind;
    logic [7:0]  filter_kind;
    logic [7:0]  interlace_kind;
  } pcsc_result_t;

  function automatic logic [7:0] sig_byte(input logic [2:0] idx);
    logic [7:0] v;
    case (idx)
      3'd0: v = 8'd137;
      3'd1: v = 8'd80;
      3'd2: v = 8'd78;
      3'd3: v = 8'd71;
      3'd4: v = 8'd13;
      3'd5: v = 8'd10;
      3'd6: v = 8'd26;
      3'd7: v = 8'd10;
      default: v = 8'd0;
    endcase
    return v;
  endfunction

  // Reflected CRC-32 over one byte; flattens into a parallel XOR network.
  function automatic logic [31:0] crc32_byte(input logic [31:0] c_in, input logic [7:0] b);
    logic [31:0] c;
    c = c_in ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? (CRC_POLY ^ (c >> 1)) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// File: src/pcsc_parser.sv
`timescale 1ns / 1ps

module pcsc_parser (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  step_i,
  input  logic [7:0]            byte_i,
  input  logic                  sof_i,
  output pcsc_pkg::pcsc_result_t result_o
);
  import pcsc_pkg::*;

  phase_e      phase_q, phase_d, cur_phase;
  logic [31:0] cnt_q, cnt_d, cur_cnt;
  logic [31:0] crc_q, crc_d, cur_crc;
  logic [31:0] len_q, len_d, cur_len;
  logic [31:0] name_q, name_d, cur_name;
  logic [31:0] scrc_q, scrc_d, cur_scrc;
  logic [7:0]  hdr_q [HDR_LEN];
  logic [7:0]  hdr_d [HDR_LEN];
  logic [7:0]  cur_hdr [HDR_LEN];
  logic        first_q, first_d, cur_first;
  logic        ninv_q, ninv_d, cur_ninv;

  logic        sig_hit, cnt_last, crc_ok, first_bad, name_alpha;
  logic [31:0] crc_upd, scrc_shift, cnt_inc;
  event_e      ev;

  // Start of file restarts from the reset state before the byte is used.
  always_comb begin
    cur_phase = sof_i ? PH_SIG   : phase_q;
    cur_cnt   = sof_i ? 32'd0    : cnt_q;
    cur_crc   = sof_i ? CRC_INIT : crc_q;
    cur_len   = sof_i ? 32'd0    : len_q;
    cur_name  = sof_i ? 32'd0    : name_q;
    cur_scrc  = sof_i ? 32'd0    : scrc_q;
    cur_first = sof_i ? 1'b1     : first_q;
    cur_ninv  = sof_i ? 1'b0     : ninv_q;
    for (int i = 0; i < HDR_LEN; i++) begin
      cur_hdr[i] = sof_i ? 8'd0 : hdr_q[i];
    end
  end

  assign sig_hit    = (byte_i == sig_byte(cur_cnt[2:0]));
  assign cnt_last   = (cur_cnt >= 32'd3);
  assign cnt_inc    = cur_cnt + 32'd1;
  assign crc_upd    = crc32_byte(cur_crc, byte_i);
  assign scrc_shift = {cur_scrc[23:0], byte_i};
  assign crc_ok     = (scrc_shift == ~cur_crc);
  assign first_bad  = cur_first && ((cur_name != NAME_IHDR) || (cur_len != 32'(HDR_LEN)));
  assign name_alpha = byte_i inside {[8'h41:8'h5A], [8'h61:8'h7A]};

  // Next state
  always_comb begin
    phase_d = cur_phase;
    cnt_d   = cur_cnt;
    crc_d   = cur_crc;
    len_d   = cur_len;
    name_d  = cur_name;
    scrc_d  = cur_scrc;
    first_d = cur_first;
    ninv_d  = cur_ninv;
    hdr_d   = cur_hdr;
    case (cur_phase)
      PH_SIG: begin
        if (!sig_hit) begin
          phase_d = PH_ERR;
        end else if (cur_cnt >= 32'(SIG_LEN - 1)) begin
          phase_d = PH_LEN;
          cnt_d   = 32'd0;
        end else begin
          cnt_d = cnt_inc;
        end
      end
      PH_LEN: begin
        len_d = {cur_len[23:0], byte_i};
        if (cnt_last) begin
          phase_d = PH_NAME;
          cnt_d   = 32'd0;
          crc_d   = CRC_INIT;
          name_d  = 32'd0;
          ninv_d  = 1'b0;
        end else begin
          cnt_d = cnt_inc;
        end
      end
      PH_NAME: begin
        name_d = {cur_name[23:0], byte_i};
        crc_d  = crc_upd;
        if (!name_alpha) ninv_d = 1'b1;
        if (cnt_last) begin
          cnt_d   = 32'd0;
          scrc_d  = 32'd0;
          phase_d = (cur_len == 32'd0) ? PH_CRC : PH_DATA;
        end else begin
          cnt_d = cnt_inc;
        end
      end
      PH_DATA: begin
        crc_d = crc_upd;
        if (cur_first && (cur_cnt < 32'(HDR_LEN))) hdr_d[cur_cnt[3:0]] = byte_i;
        cnt_d = cnt_inc;
        if (cnt_inc == cur_len) begin
          phase_d = PH_CRC;
          cnt_d   = 32'd0;
        end
      end
      PH_CRC: begin
        scrc_d = scrc_shift;
        if (cnt_last) begin
          cnt_d = 32'd0;
          if (!crc_ok || cur_ninv || first_bad) begin
            phase_d = PH_ERR;
          end else begin
            first_d = 1'b0;
            if (cur_name == NAME_IEND) begin
              phase_d = PH_DONE;
            end else begin
              phase_d = PH_LEN;
              len_d   = 32'd0;
            end
          end
        end else begin
          cnt_d = cnt_inc;
        end
      end
      default: ;
    endcase
  end

  // Event code, with CRC error ahead of name error ahead of first chunk error
  always_comb begin
    ev = EV_BUSY;
    case (cur_phase)
      PH_SIG: begin
        if (!sig_hit) ev = EV_SIG_ERR;
        else if (cur_cnt >= 32'(SIG_LEN - 1)) ev = EV_SIG_OK;
      end
      PH_LEN:  ev = EV_BUSY;
      PH_NAME: if (cnt_last) ev = EV_HEADER;
      PH_DATA: ev = EV_DATA;
      PH_CRC: begin
        if (cnt_last) begin
          if (!crc_ok) ev = EV_CRC_ERR;
          else if (cur_ninv) ev = EV_NAME_ERR;
          else if (first_bad) ev = EV_FIRST_ERR;
          else if (cur_name == NAME_IEND) ev = EV_IEND;
          else ev = EV_CHUNK_OK;
        end
      end
      default: ev = EV_IGNORED;
    endcase
  end

  always_comb begin
    result_o.event_res        = ev;
    result_o.out_byte         = (cur_phase == PH_DATA) ? byte_i : 8'd0;
    result_o.chunk_length     = len_d;
    result_o.chunk_name       = name_d;
    result_o.is_idat          = (name_d == NAME_IDAT);
    result_o.image_width      = {hdr_d[0], hdr_d[1], hdr_d[2], hdr_d[3]};
    result_o.image_height     = {hdr_d[4], hdr_d[5], hdr_d[6], hdr_d[7]};
    result_o.sample_depth     = hdr_d[8];
    result_o.pixel_kind       = hdr_d[9];
    result_o.compression_kind = hdr_d[10];
    result_o.filter_kind      = hdr_d[11];
    result_o.interlace_kind   = hdr_d[12];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_SIG;
      cnt_q   <= 32'd0;
      crc_q   <= CRC_INIT;
      len_q   <= 32'd0;
      name_q  <= 32'd0;
      scrc_q  <= 32'd0;
      first_q <= 1'b1;
      ninv_q  <= 1'b0;
      for (int i = 0; i < HDR_LEN; i++) begin
        hdr_q[i] <= 8'd0;
      end
    end else if (step_i) begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      crc_q   <= crc_d;
      len_q   <= len_d;
      name_q  <= name_d;
      scrc_q  <= scrc_d;
      first_q <= first_d;
      ninv_q  <= ninv_d;
      hdr_q   <= hdr_d;
    end
  end

  a_err_latches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && (ev == EV_SIG_ERR || ev == EV_CRC_ERR || ev == EV_NAME_ERR ||
               ev == EV_FIRST_ERR) |=> phase_q == PH_ERR)
    else $error("error event did not latch the error phase");

  a_iend_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && ev == EV_IEND |=> phase_q == PH_DONE && !first_q)
    else $error("IEND did not end parsing");

  a_data_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_DATA |-> cnt_q < len_q)
    else $error("data count ran past chunk length");

  a_field_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_LEN || phase_q == PH_NAME || phase_q == PH_CRC) |-> cnt_q < 32'd4)
    else $error("field byte count out of range");

endmodule

// File: src/png_chunk_stream_checker_top.sv
`timescale 1ns / 1ps
// An accepted byte's result is registered in the output register. One byte per cycle
// unless the output stalls; the per-byte CRC-32 update is a single XOR network. The
// input side stays ready while the held result is taken in the same cycle.
// Reset (rst_ni low, asynchronous) empties the output register and returns parsing
// to the signature check; a byte with start_of_file set restarts parsing as well.

module png_chunk_stream_checker_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [7:0]                    s_axis_tdata,  // [7:0] data_byte
  input  logic                          s_axis_tuser,  // [0] start_of_file
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [7:0] out_byte, [39:8] chunk_length, [71:40] chunk_name, [72] is_idat,
  // [104:73] image_width, [136:105] image_height, [144:137] sample_depth,
  // [152:145] pixel_kind, [160:153] compression_kind, [168:161] filter_kind,
  // [176:169] interlace_kind, [183:177] zero
  output logic [pcsc_pkg::TDATA_W-1:0] m_axis_tdata,
  output logic [pcsc_pkg::TUSER_W-1:0] m_axis_tuser   // [3:0] event_res
);
  import pcsc_pkg::*;

  logic         accept;
  logic         valid_q;
  pcsc_result_t result;
  pcsc_result_t res_q;

  assign s_axis_tready = !valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  pcsc_parser u_parser (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (accept),
    .byte_i   (s_axis_tdata),
    .sof_i    (s_axis_tuser),
    .result_o (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (accept) begin
      valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      valid_q <= 1'b0;
    end
  end

  // Hold the result until the downstream side takes it.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q <= result;
    end
  end

  assign m_axis_tvalid = valid_q;
  assign m_axis_tuser  = res_q.event_res;
  assign m_axis_tdata  = {7'd0,
                          res_q.interlace_kind,
                          res_q.filter_kind,
                          res_q.compression_kind,
                          res_q.pixel_kind,
                          res_q.sample_depth,
                          res_q.image_height,
                          res_q.image_width,
                          res_q.is_idat,
                          res_q.chunk_name,
                          res_q.chunk_length,
                          res_q.out_byte};

endmodule
